// ===== design/tpf_pkg.sv =====
// ----------------------------------------------------------------------------
// tpf_pkg
// Shared constants, types and the pixel formatting function of the texture
// pixel format converter.
// ----------------------------------------------------------------------------
package tpf_pkg;

   localparam int PALETTE_BYTES_DEFAULT = 1024;

   // source format codes
   localparam logic [3:0] FMT_IDX4_BGR  = 4'd0;
   localparam logic [3:0] FMT_IDX4_BGRA = 4'd1;
   localparam logic [3:0] FMT_IDX8_BGR  = 4'd2;
   localparam logic [3:0] FMT_IDX8_RGBA = 4'd3;
   localparam logic [3:0] FMT_BGR5A1    = 4'd4;
   localparam logic [3:0] FMT_RGB565    = 4'd5;
   localparam logic [3:0] FMT_BGR24     = 4'd6;
   localparam logic [3:0] FMT_BGRA32    = 4'd7;
   localparam logic [3:0] FMT_ARGB4444  = 4'd8;

   // request function codes
   localparam logic FUNC_CONVERT   = 1'b0;
   localparam logic FUNC_PAL_WRITE = 1'b1;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // four bytes in memory order, byte 0 in the low bits
   typedef logic [3:0][7:0] pixel_type;

   // palette access issued by the request stage
   typedef struct packed {
      logic       wr_en;
      logic [9:0] wr_addr;
      logic [7:0] wr_data;
      logic       rd_en;
      logic [9:0] rd_base;
   } pal_ctrl_type;

   function automatic logic known_format(logic [3:0] fmt);
      return fmt <= FMT_ARGB4444;
   endfunction

   function automatic logic uses_palette(logic [3:0] fmt);
      return fmt <= FMT_IDX8_RGBA;
   endfunction

   function automatic logic is_idx4(logic [3:0] fmt);
      return (fmt == FMT_IDX4_BGR) || (fmt == FMT_IDX4_BGRA);
   endfunction

   // entry holds palette bytes base+0 .. base+3
   function automatic pixel_type convert_pixel(logic [3:0] fmt, logic [31:0] word,
                                               pixel_type entry);
      pixel_type px;
      px = '0;
      case (fmt)
         FMT_IDX4_BGR, FMT_IDX8_BGR: begin
            px = {ALPHA_OPAQUE, entry[0], entry[1], entry[2]};
         end
         FMT_IDX4_BGRA: begin
            px = {entry[3], entry[0], entry[1], entry[2]};
         end
         FMT_IDX8_RGBA: begin
            px = entry;
         end
         FMT_BGR5A1: begin
            px[0] = {word[14:10], 3'b000};
            px[1] = {word[9:5], 3'b000};
            px[2] = {word[4:0], 3'b000};
            px[3] = word[15] ? ALPHA_OPAQUE : 8'h00;
         end
         FMT_RGB565: begin
            px[0] = {word[15:11], 3'b000};
            px[1] = {word[10:5], 2'b00};
            px[2] = {word[4:0], 3'b000};
            px[3] = ALPHA_OPAQUE;
         end
         FMT_BGR24: begin
            px = {ALPHA_OPAQUE, word[7:0], word[15:8], word[23:16]};
         end
         FMT_BGRA32: begin
            px = {word[31:24], word[7:0], word[15:8], word[23:16]};
         end
         FMT_ARGB4444: begin
            px[0] = {word[11:8], 4'h0};
            px[1] = {word[7:4], 4'h0};
            px[2] = {word[3:0], 4'h0};
            px[3] = {word[15:12], 4'h0};
         end
         default: begin
            px = '0;
         end
      endcase
      return px;
   endfunction

endpackage

// ===== design/texture_pixel_format_converter.sv =====
// ----------------------------------------------------------------------------
// texture_pixel_format_converter
// Converts texture source words into RGBA8888 pixels, with a loadable palette.
// ----------------------------------------------------------------------------
// Each request either writes one palette byte (tuser = 1) or converts one
// source word (tuser = 0) in the format held by the csr register. Direct and
// 8-bit indexed formats give one pixel per request; the 4-bit indexed
// formats give two pixels per request, low nibble first, one after the
// other, since the response port and the palette read port each move one
// pixel a cycle while the response port is not stalled. Palette writes give
// no response; unknown formats drop the request. A pixel passes the request
// stage, the palette read stage and the response register before it is
// offered on the response port. The palette is not cleared by reset: read
// only entries that were written. Write the csr register only while idle.
// ----------------------------------------------------------------------------
module texture_pixel_format_converter #(
   parameter int PALETTE_BYTES = tpf_pkg::PALETTE_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // source_word[31:0], palette_address[41:32], palette_byte[49:42], zero fill
   input  logic [55:0] req_tdata,
   // func[0]
   input  logic [0:0]  req_tuser,
   // end_of_image
   input  logic        req_tlast,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_byte0[7:0], out_byte1[15:8], out_byte2[23:16], out_byte3[31:24]
   output logic [31:0] rsp_tdata,
   // last_of_image[0]
   output logic [0:0]  rsp_tuser,
   // last_of_item
   output logic        rsp_tlast,
   // csr write channel: source_format
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_wdata
);

   // format register
   logic [3:0] fmt_ff;

   // request stage
   logic        a_valid_ff, a_valid_in;
   logic        a_half_ff, a_half_in;
   logic        a_func_ff;
   logic [31:0] a_word_ff;
   logic        a_eoi_ff;
   logic [9:0]  a_addr_ff;
   logic [7:0]  a_byte_ff;

   // palette read stage
   logic        b_valid_ff, b_valid_in;
   logic [31:0] b_word_ff;
   logic        b_last_ff;
   logic        b_eoi_ff;

   // response register
   logic        c_valid_ff, c_valid_in;
   logic [31:0] c_data_ff;
   logic        c_last_ff;
   logic        c_eoi_ff;

   logic                  req_fire;
   logic                  is_write;
   logic                  is_convert;
   logic                  is_drop;
   logic                  idx4;
   logic                  last_px;
   logic                  b_adv;
   logic                  b_free;
   logic                  issue;
   logic                  a_done;
   logic [3:0]            nibble;
   logic [7:0]            pal_index;
   logic [9:0]            pal_base;
   tpf_pkg::pal_ctrl_type pal_ctrl;
   tpf_pkg::pixel_type    pal_bytes;
   tpf_pkg::pixel_type    pixel;

   assign csr_ready = 1'b1;
   assign req_fire  = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= tpf_pkg::FMT_IDX4_BGR;
      end else if (csr_valid && csr_ready) begin
         fmt_ff <= csr_wdata;
      end
   end

   // decode the held request
   assign idx4       = tpf_pkg::is_idx4(fmt_ff);
   assign is_write   = a_valid_ff && (a_func_ff == tpf_pkg::FUNC_PAL_WRITE);
   assign is_convert = a_valid_ff && (a_func_ff == tpf_pkg::FUNC_CONVERT)
                       && tpf_pkg::known_format(fmt_ff);
   assign is_drop    = a_valid_ff && (a_func_ff == tpf_pkg::FUNC_CONVERT)
                       && !tpf_pkg::known_format(fmt_ff);
   assign last_px    = !idx4 || a_half_ff;

   // advance the pipeline only where the next stage has room
   assign b_adv  = b_valid_ff && (!c_valid_ff || rsp_tready);
   assign b_free = !b_valid_ff || b_adv;
   assign issue  = is_convert && b_free;
   assign a_done = is_write || is_drop || (issue && last_px);

   assign req_tready = !a_valid_ff || a_done;

   assign a_valid_in = req_fire || (a_valid_ff && !a_done);
   always_comb begin
      a_half_in = a_half_ff;
      if (a_done) begin
         a_half_in = 1'b0;
      end else if (issue && idx4) begin
         a_half_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         a_half_ff  <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         a_half_ff  <= a_half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_func_ff <= req_tuser[0];
         a_word_ff <= req_tdata[31:0];
         a_eoi_ff  <= req_tlast;
         a_addr_ff <= req_tdata[41:32];
         a_byte_ff <= req_tdata[49:42];
      end
   end

   // palette entry address: 3 bytes a BGR entry, 4 bytes a BGRA or RGBA entry
   assign nibble    = a_half_ff ? a_word_ff[7:4] : a_word_ff[3:0];
   assign pal_index = idx4 ? {4'h0, nibble} : a_word_ff[7:0];
   always_comb begin
      if ((fmt_ff == tpf_pkg::FMT_IDX4_BGR) || (fmt_ff == tpf_pkg::FMT_IDX8_BGR)) begin
         pal_base = 10'({pal_index, 1'b0}) + 10'(pal_index);
      end else begin
         pal_base = {pal_index, 2'b00};
      end
   end

   always_comb begin
      pal_ctrl.wr_en   = is_write;
      pal_ctrl.wr_addr = a_addr_ff;
      pal_ctrl.wr_data = a_byte_ff;
      pal_ctrl.rd_en   = issue && tpf_pkg::uses_palette(fmt_ff);
      pal_ctrl.rd_base = pal_base;
   end

   tpf_palette #(
      .PALETTE_BYTES (PALETTE_BYTES)
   ) u_palette (
      .clock    (clock),
      .ctrl     (pal_ctrl),
      .rd_bytes (pal_bytes)
   );

   // palette read stage: hold while the response register is full
   assign b_valid_in = issue || (b_valid_ff && !b_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b_word_ff <= a_word_ff;
         b_last_ff <= last_px;
         b_eoi_ff  <= last_px && a_eoi_ff;
      end
   end

   assign pixel = tpf_pkg::convert_pixel(fmt_ff, b_word_ff, pal_bytes);

   // response register
   assign c_valid_in = b_adv || (c_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         c_data_ff <= pixel;
         c_last_ff <= b_last_ff;
         c_eoi_ff  <= b_eoi_ff;
      end
   end

   assign rsp_tvalid   = c_valid_ff;
   assign rsp_tdata    = c_data_ff;
   assign rsp_tlast    = c_last_ff;
   assign rsp_tuser[0] = c_eoi_ff;

endmodule

// ===== design/tpf_ram.sv =====
// ----------------------------------------------------------------------------
// tpf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tpf_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tpf_palette.sv =====
// ----------------------------------------------------------------------------
// tpf_palette
// Palette store split into four byte banks so that one read returns the
// four bytes starting at any byte address.
// ----------------------------------------------------------------------------
module tpf_palette #(
   parameter int PALETTE_BYTES = tpf_pkg::PALETTE_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  tpf_pkg::pal_ctrl_type ctrl,
   output tpf_pkg::pixel_type    rd_bytes
);

   localparam int ROWS  = (PALETTE_BYTES + 3) / 4;
   localparam int ROW_W = $clog2(ROWS);

   logic [3:0][7:0] bank_data;
   logic [3:0]      bank_ok_in;
   logic [3:0]      bank_ok_ff;
   logic [1:0]      base_lo_ff;
   logic            wr_in_store;

   assign wr_in_store = {1'b0, ctrl.wr_addr} < 11'(PALETTE_BYTES);

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [1:0]       rd_off;
      logic [10:0]      rd_addr;
      logic [ROW_W-1:0] rd_row;
      logic             wr_sel;

      // bank b serves the one byte of base..base+3 whose low bits equal b
      assign rd_off        = 2'(b) - ctrl.rd_base[1:0];
      assign rd_addr       = {1'b0, ctrl.rd_base} + {9'b0, rd_off};
      assign bank_ok_in[b] = rd_addr < 11'(PALETTE_BYTES);
      assign rd_row        = bank_ok_in[b] ? rd_addr[ROW_W+1:2] : '0;
      assign wr_sel        = ctrl.wr_en && wr_in_store && (ctrl.wr_addr[1:0] == 2'(b));

      tpf_ram #(
         .WIDTH (8),
         .DEPTH (ROWS)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wr_sel),
         .wr_addr (ctrl.wr_addr[ROW_W+1:2]),
         .wr_data (ctrl.wr_data),
         .rd_en   (ctrl.rd_en),
         .rd_addr (rd_row),
         .rd_data (bank_data[b])
      );
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         bank_ok_ff <= bank_ok_in;
         base_lo_ff <= ctrl.rd_base[1:0];
      end
   end

   // rotate banks back into byte order; bytes beyond the store read as zero
   always_comb begin
      logic [1:0] sel;
      for (int k = 0; k < 4; k++) begin
         sel         = base_lo_ff + 2'(k);
         rd_bytes[k] = bank_ok_ff[sel] ? bank_data[sel] : 8'h00;
      end
   end

endmodule

// ===== design/tpf_checker.sv =====
// ----------------------------------------------------------------------------
// tpf_checker
// Port-level checks of the texture pixel format converter, bound to the top.
// ----------------------------------------------------------------------------
module tpf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // end of image only ever rides on the last pixel of a request
   a_eoi_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("last_of_image without last_of_item");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // a stalled response stays offered
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("response payload changed while stalled");

endmodule

bind texture_pixel_format_converter tpf_checker u_tpf_checker (.*);
